// File: hdl/kvt_pkg.sv
package kvt_pkg;

   // default sizing, handed to the top level parameters
   localparam int ENTRIES_DEF   = 16;
   localparam int KEY_BYTES_DEF = 8;

   // fixed field widths of the request and response transfers
   localparam int OP_W        = 3;
   localparam int WORD_W      = 64;
   localparam int STATUS_W    = 3;
   localparam int COUNT_W     = 5;
   localparam int REQ_TDATA_W = 136;
   localparam int RSP_TDATA_W = 136;

   typedef enum logic [OP_W-1:0] {
      OP_LOOKUP = 3'd0,
      OP_INSERT = 3'd1,
      OP_REMOVE = 3'd2,
      OP_UPDATE = 3'd3,
      OP_LEAST  = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_MISSING  = 3'd1,
      ST_REPEATED = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_RESP
   } state_type;

   typedef enum logic [1:0] {
      CMD_INSERT,
      CMD_CLEAR,
      CMD_UPDATE
   } cmd_kind_type;

   // write command broadcast to every slot
   typedef struct packed {
      logic         en;
      cmd_kind_type kind;
   } cmd_type;

   // flags carried by the search probe from slot to slot
   typedef struct packed {
      logic live;
      logic hit;
      logic free_found;
      logic least_found;
   } probe_flags_type;

endpackage

// File: hdl/kvt_cell.sv
module kvt_cell #(
   parameter int KEY_W    = 64,
   parameter int IDX_W    = 4,
   parameter int CELL_IDX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   // search key, held steady for the whole scan
   input  logic [KEY_W-1:0]       key_i,
   // probe from the left neighbor
   input  kvt_pkg::probe_flags_type flags_i,
   input  logic [IDX_W-1:0]       hit_idx_i,
   input  logic [kvt_pkg::WORD_W-1:0] hit_value_i,
   input  logic [IDX_W-1:0]       free_idx_i,
   input  logic [KEY_W-1:0]       least_i,
   // probe to the right neighbor
   output kvt_pkg::probe_flags_type flags_o,
   output logic [IDX_W-1:0]       hit_idx_o,
   output logic [kvt_pkg::WORD_W-1:0] hit_value_o,
   output logic [IDX_W-1:0]       free_idx_o,
   output logic [KEY_W-1:0]       least_o,
   // write command
   input  kvt_pkg::cmd_type       cmd_i,
   input  logic [IDX_W-1:0]       cmd_idx_i,
   input  logic [KEY_W-1:0]       cmd_key_i,
   input  logic [kvt_pkg::WORD_W-1:0] cmd_value_i
);
   import kvt_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

   logic                 valid_ff, valid_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [WORD_W-1:0]    value_ff, value_in;

   probe_flags_type      flags_ff, flags_in;
   logic [IDX_W-1:0]     hit_idx_ff, hit_idx_in;
   logic [WORD_W-1:0]    hit_value_ff, hit_value_in;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in;
   logic [KEY_W-1:0]     least_ff, least_in;

   logic match;
   logic take_free;
   logic take_least;
   logic sel;

   // compare this entry against the passing probe
   always_comb begin
      match      = valid_ff && (key_ff == key_i);
      take_free  = !flags_i.free_found && !valid_ff;
      take_least = valid_ff && (!flags_i.least_found || (key_ff < least_i));

      flags_in.live        = flags_i.live;
      flags_in.hit         = flags_i.hit | match;
      flags_in.free_found  = flags_i.free_found | take_free;
      flags_in.least_found = flags_i.least_found | take_least;
      hit_idx_in   = match ? MY_IDX : hit_idx_i;
      hit_value_in = match ? value_ff : hit_value_i;
      free_idx_in  = take_free ? MY_IDX : free_idx_i;
      least_in     = take_least ? key_ff : least_i;
   end

   // probe stage toward the neighbor
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_idx_ff   <= hit_idx_in;
      hit_value_ff <= hit_value_in;
      free_idx_ff  <= free_idx_in;
      least_ff     <= least_in;
   end

   // apply the broadcast write when it targets this slot
   always_comb begin
      sel      = cmd_i.en && (cmd_idx_i == MY_IDX);
      valid_in = valid_ff;
      key_in   = key_ff;
      value_in = value_ff;
      if (sel) begin
         case (cmd_i.kind)
            CMD_INSERT: begin
               valid_in = 1'b1;
               key_in   = cmd_key_i;
               value_in = cmd_value_i;
            end
            CMD_CLEAR: begin
               valid_in = 1'b0;
            end
            CMD_UPDATE: begin
               value_in = cmd_value_i;
            end
            default: begin
               valid_in = valid_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign flags_o     = flags_ff;
   assign hit_idx_o   = hit_idx_ff;
   assign hit_value_o = hit_value_ff;
   assign free_idx_o  = free_idx_ff;
   assign least_o     = least_ff;

endmodule

// File: hdl/key_value_table.sv
// Key and value table with unique keys, held in a row of slots.
// Request channel (req_*): one transfer carries op, key and data_in.
//   ops: lookup, insert, remove, update value, smallest key.
// Response channel (rsp_*): exactly one transfer per request with status,
//   data_out, least_key and the entry count after the operation.
// A request travels as a probe through the row of slots, one slot per
// cycle, collecting the key match, the lowest free slot and the smallest
// key; at the end of the row the result is formed and, for a successful
// insert, remove or update, a single write command updates the chosen slot.
// Requests are handled one at a time; the next request is taken in the
// cycle after the response transfer.
// Reset empties the table (all slots invalid, count zero) and drops any
// request in flight. A stalled receiver holds the response steady and
// keeps req_tready low until the response transfer.
module key_value_table #(
   parameter int ENTRIES   = kvt_pkg::ENTRIES_DEF,
   parameter int KEY_BYTES = kvt_pkg::KEY_BYTES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // op [2:0], key [66:3], data_in [130:67], zero pad [135:131]
   input  logic [kvt_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // status [2:0], data_out [66:3], least_key [130:67], entry_count [135:131]
   output logic [kvt_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready
);
   import kvt_pkg::*;

   localparam int KEY_W = 8 * KEY_BYTES;
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);

   state_type state_ff, state_in;

   logic req_xfer;
   logic rsp_xfer;
   logic scan_done;

   // request held during the scan
   op_type             op_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [WORD_W-1:0]  value_ff;
   logic               start_ff;

   logic [CNT_W-1:0]   count_ff, count_in;

   // response register
   status_type         status_ff, status_in;
   logic [WORD_W-1:0]  data_out_ff, data_out_in;
   logic [KEY_W-1:0]   least_ff, least_in;

   // write command register
   cmd_type            cmd_ff, cmd_in;
   logic [IDX_W-1:0]   cmd_idx_ff, cmd_idx_in;

   // probe chain, position 0 enters the first slot
   probe_flags_type    flags_c     [ENTRIES+1];
   logic [IDX_W-1:0]   hit_idx_c   [ENTRIES+1];
   logic [WORD_W-1:0]  hit_value_c [ENTRIES+1];
   logic [IDX_W-1:0]   free_idx_c  [ENTRIES+1];
   logic [KEY_W-1:0]   least_c     [ENTRIES+1];

   probe_flags_type    tail;

   logic [CNT_W+COUNT_W-1:0] count_ext;
   logic [KEY_W+WORD_W-1:0]  least_ext;

   // handshake and state machine outputs
   always_comb begin
      req_tready = (state_ff == S_IDLE) && !reset;
      rsp_tvalid = (state_ff == S_RESP);
      scan_done  = (state_ff == S_SCAN) && tail.live;
   end

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (tail.live) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_xfer) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         start_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= req_xfer;
      end
   end

   // capture the request
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff    <= op_type'(req_tdata[OP_W-1:0]);
         key_ff   <= req_tdata[OP_W +: KEY_W];
         value_ff <= req_tdata[OP_W+WORD_W +: WORD_W];
      end
   end

   // probe entering the row
   always_comb begin
      flags_c[0].live        = start_ff;
      flags_c[0].hit         = 1'b0;
      flags_c[0].free_found  = 1'b0;
      flags_c[0].least_found = 1'b0;
      hit_idx_c[0]   = '0;
      hit_value_c[0] = '0;
      free_idx_c[0]  = '0;
      least_c[0]     = '0;
   end

   // row of slots
   for (genvar i = 0; i < ENTRIES; i++) begin : g_slot
      kvt_cell #(
         .KEY_W    (KEY_W),
         .IDX_W    (IDX_W),
         .CELL_IDX (i)
      ) u_slot (
         .clock       (clock),
         .reset       (reset),
         .key_i       (key_ff),
         .flags_i     (flags_c[i]),
         .hit_idx_i   (hit_idx_c[i]),
         .hit_value_i (hit_value_c[i]),
         .free_idx_i  (free_idx_c[i]),
         .least_i     (least_c[i]),
         .flags_o     (flags_c[i+1]),
         .hit_idx_o   (hit_idx_c[i+1]),
         .hit_value_o (hit_value_c[i+1]),
         .free_idx_o  (free_idx_c[i+1]),
         .least_o     (least_c[i+1]),
         .cmd_i       (cmd_ff),
         .cmd_idx_i   (cmd_idx_ff),
         .cmd_key_i   (key_ff),
         .cmd_value_i (value_ff)
      );
   end

   assign tail = flags_c[ENTRIES];

   // result and write command at the end of the row
   always_comb begin
      status_in   = ST_OK;
      data_out_in = '0;
      least_in    = '0;
      count_in    = count_ff;
      cmd_in.en   = 1'b0;
      cmd_in.kind = CMD_UPDATE;
      cmd_idx_in  = hit_idx_c[ENTRIES];
      case (op_ff)
         OP_LOOKUP: begin
            if (tail.hit) begin
               data_out_in = hit_value_c[ENTRIES];
            end else begin
               status_in = ST_MISSING;
            end
         end
         OP_INSERT: begin
            if (tail.hit) begin
               status_in = ST_REPEATED;
            end else if (tail.free_found) begin
               cmd_in.en   = 1'b1;
               cmd_in.kind = CMD_INSERT;
               cmd_idx_in  = free_idx_c[ENTRIES];
               count_in    = count_ff + 1'b1;
            end else begin
               status_in = ST_FULL;
            end
         end
         OP_REMOVE: begin
            if (tail.hit) begin
               cmd_in.en   = 1'b1;
               cmd_in.kind = CMD_CLEAR;
               count_in    = count_ff - 1'b1;
            end else begin
               status_in = ST_MISSING;
            end
         end
         OP_UPDATE: begin
            if (tail.hit) begin
               cmd_in.en   = 1'b1;
               cmd_in.kind = CMD_UPDATE;
            end else begin
               status_in = ST_MISSING;
            end
         end
         OP_LEAST: begin
            if (tail.least_found) begin
               least_in = least_c[ENTRIES];
            end else begin
               status_in = ST_EMPTY;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   // control registers updated when the probe leaves the row
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cmd_ff   <= '0;
      end else begin
         if (scan_done) begin
            count_ff <= count_in;
            cmd_ff   <= cmd_in;
         end else begin
            cmd_ff.en <= 1'b0;
         end
      end
   end

   // response payload and write target
   always_ff @(posedge clock) begin
      if (scan_done) begin
         status_ff   <= status_in;
         data_out_ff <= data_out_in;
         least_ff    <= least_in;
         cmd_idx_ff  <= cmd_idx_in;
      end
   end

   // pack the response transfer
   always_comb begin
      count_ext = {{COUNT_W{1'b0}}, count_ff};
      least_ext = {{WORD_W{1'b0}}, least_ff};
      rsp_tdata = {count_ext[COUNT_W-1:0], least_ext[WORD_W-1:0], data_out_ff,
                   status_ff};
   end

   // the stored count never exceeds the capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count above capacity");

   // a write command is only applied while the response waits
   a_cmd_in_resp: assert property (@(posedge clock) disable iff (reset)
      cmd_ff.en |-> (state_ff == S_RESP))
      else $error("write command outside response phase");

   // the probe leaves the row only during a scan
   a_tail_scan: assert property (@(posedge clock) disable iff (reset)
      tail.live |-> (state_ff == S_SCAN))
      else $error("probe left the row outside a scan");

   // a successful insert raises the count by one
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (scan_done && (op_ff == OP_INSERT) && !tail.hit && tail.free_found)
      |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert did not raise the count");

endmodule
